FILE: hw/rtl/psseq_pkg.sv
`timescale 1ns / 1ps

package psseq_pkg;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_HOME    = 4'd2,
    PH_SEEK    = 4'd3,
    PH_LEAVE   = 4'd4,
    PH_OFFSET  = 4'd5,
    PH_BEGIN   = 4'd6,
    PH_SEARCH  = 4'd7,
    PH_FAIL    = 4'd8,
    PH_ADVANCE = 4'd9,
    PH_HOLD    = 4'd10,
    PH_RETURN  = 4'd11,
    PH_FINISH  = 4'd12
  } phase_e;

  // motor commands
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_GO_MIN   = 3'd1,
    CMD_GO_MAX   = 3'd2,
    CMD_MOVE_TO  = 3'd3,
    CMD_GO_ZERO  = 3'd4,
    CMD_SET_ZERO = 3'd5,
    CMD_STOP     = 3'd6
  } cmd_e;

  // event markers
  typedef enum logic [2:0] {
    MRK_NONE       = 3'd0,
    MRK_BEGIN      = 3'd1,
    MRK_THRESHOLD  = 3'd2,
    MRK_FAIL       = 3'd3,
    MRK_POSITIONED = 3'd4,
    MRK_HOLD_END   = 3'd5,
    MRK_RETURNED   = 3'd6,
    MRK_SCAN_END   = 3'd7
  } marker_e;

  // request kinds
  localparam logic [1:0] REQ_POLL  = 2'd0;
  localparam logic [1:0] REQ_OPEN  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_SCAN_LENGTH = 2'd0;
  localparam logic [1:0] CFG_SCAN_AREA   = 2'd1;
  localparam logic [1:0] CFG_START_VALUE = 2'd2;

  localparam logic [31:0] HOME_OFFSET = 32'd400;
  localparam logic [31:0] MIN_LIMIT   = 32'hFFFF_FC18;  // -1000

  typedef struct packed {
    logic [31:0] scan_length_ms;
    logic [15:0] scan_area;
    logic [9:0]  start_value;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        start_switch;
    logic        home_switch;
    logic [9:0]  sensor_value;
    logic [31:0] motor_position;
    logic [31:0] motor_max;
    logic        dest_reached;
    logic        motor_idle;
    logic        ms_elapsed;
  } in_item_t;

  typedef struct packed {
    cmd_e        motor_cmd;
    logic [31:0] motor_target;
    logic        motor_enable;
    marker_e     marker;
    logic        sending;
    logic        recording;
    logic        failed;
    phase_e      phase_out;
  } out_item_t;

endpackage

FILE: hw/rtl/psseq_in_reg.sv
`timescale 1ns / 1ps

module psseq_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psseq_pkg::in_item_t item_i,
  input  logic                advance_i,
  output logic                valid_o,
  output psseq_pkg::in_item_t item_o
);
  import psseq_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  // free when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hw/rtl/psseq_core.sv
`timescale 1ns / 1ps

module psseq_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psseq_pkg::cfg_t      cfg_i,
  input  logic                 step_i,
  input  psseq_pkg::in_item_t  item_i,
  output psseq_pkg::out_item_t res_o
);
  import psseq_pkg::*;

  phase_e      phase_q, phase_d;
  logic        conn_q, conn_d;
  logic        rec_q, rec_d;
  logic        fail_q, fail_d;
  logic        en_q, en_d;
  logic [31:0] timer_q, timer_d;

  phase_e         ph_eff;
  logic           run;
  logic           is_open, is_close;
  logic signed [32:0] reach;
  logic           over, hit, hold_done;
  logic [31:0]    timer_inc;
  cmd_e           cmd;
  logic [31:0]    target;
  marker_e        marker;

  assign is_open  = (item_i.req_type == REQ_OPEN);
  assign is_close = (item_i.req_type == REQ_CLOSE);
  assign run      = conn_q && !fail_q;

  // phase seen by a poll: unused codes fold to idle, start press leaves idle
  always_comb begin
    ph_eff = (phase_q > PH_FINISH) ? PH_IDLE : phase_q;
    if (item_i.start_switch && ph_eff == PH_IDLE) begin
      ph_eff = PH_START;
    end
  end

  // travel limit check and threshold
  assign reach = $signed({item_i.motor_position[31], item_i.motor_position})
               + $signed({17'd0, cfg_i.scan_area});
  assign over  = reach > $signed({item_i.motor_max[31], item_i.motor_max});
  assign hit   = item_i.sensor_value >= cfg_i.start_value;

  // saturating hold timer
  assign timer_inc = (item_i.ms_elapsed && timer_q != '1) ? timer_q + 32'd1 : timer_q;
  assign hold_done = timer_inc > cfg_i.scan_length_ms;

  // next state
  always_comb begin
    phase_d = phase_q;
    conn_d  = conn_q;
    rec_d   = rec_q;
    fail_d  = fail_q;
    en_d    = en_q;
    timer_d = timer_q;
    if (is_open) begin
      phase_d = PH_IDLE;
      conn_d  = 1'b1;
      rec_d   = 1'b0;
      fail_d  = 1'b0;
    end else if (is_close) begin
      phase_d = PH_IDLE;
      conn_d  = 1'b0;
      rec_d   = 1'b0;
      fail_d  = 1'b0;
      en_d    = 1'b0;
    end else begin
      phase_d = ph_eff;
      if (run) begin
        case (ph_eff)
          PH_START: phase_d = PH_HOME;
          PH_HOME: begin
            en_d    = 1'b1;
            phase_d = item_i.home_switch ? PH_LEAVE : PH_SEEK;
          end
          PH_SEEK: begin
            if (item_i.home_switch) phase_d = PH_LEAVE;
          end
          PH_LEAVE: begin
            if (!item_i.home_switch) phase_d = PH_OFFSET;
          end
          PH_OFFSET: begin
            if (item_i.dest_reached) phase_d = PH_BEGIN;
          end
          PH_BEGIN: begin
            en_d    = 1'b1;
            phase_d = PH_SEARCH;
          end
          PH_SEARCH: begin
            if (hit) begin
              rec_d   = 1'b1;
              phase_d = PH_ADVANCE;
            end else if (over) begin
              phase_d = PH_FAIL;
            end
          end
          PH_FAIL: begin
            fail_d  = 1'b1;
            en_d    = 1'b0;
            phase_d = PH_IDLE;
          end
          PH_ADVANCE: begin
            if (item_i.dest_reached) begin
              timer_d = '0;
              phase_d = PH_HOLD;
            end
          end
          PH_HOLD: begin
            timer_d = timer_inc;
            if (hold_done) phase_d = PH_RETURN;
          end
          PH_RETURN: begin
            if (item_i.dest_reached) phase_d = PH_FINISH;
          end
          PH_FINISH: begin
            if (item_i.motor_idle) begin
              rec_d   = 1'b0;
              fail_d  = 1'b0;
              en_d    = 1'b0;
              phase_d = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // command, target and marker of this word
  always_comb begin
    cmd    = CMD_NONE;
    target = '0;
    marker = MRK_NONE;
    if (is_close) begin
      cmd = CMD_STOP;
    end else if (!is_open && run) begin
      case (ph_eff)
        PH_HOME: cmd = item_i.home_switch ? CMD_GO_MAX : CMD_GO_MIN;
        PH_SEEK: begin
          if (item_i.home_switch) cmd = CMD_GO_MAX;
        end
        PH_LEAVE: begin
          if (!item_i.home_switch) begin
            cmd    = CMD_MOVE_TO;
            target = item_i.motor_position + HOME_OFFSET;
          end
        end
        PH_OFFSET: begin
          if (item_i.dest_reached) begin
            cmd    = CMD_SET_ZERO;
            target = MIN_LIMIT;
          end
        end
        PH_BEGIN: begin
          cmd    = CMD_GO_MAX;
          marker = MRK_BEGIN;
        end
        PH_SEARCH: begin
          if (hit) begin
            cmd    = CMD_MOVE_TO;
            target = reach[31:0];
            marker = MRK_THRESHOLD;
          end
        end
        PH_FAIL: begin
          cmd    = CMD_STOP;
          marker = MRK_FAIL;
        end
        PH_ADVANCE: begin
          if (item_i.dest_reached) marker = MRK_POSITIONED;
        end
        PH_HOLD: begin
          if (hold_done) begin
            cmd    = CMD_GO_ZERO;
            marker = MRK_HOLD_END;
          end
        end
        PH_RETURN: begin
          if (item_i.dest_reached) marker = MRK_RETURNED;
        end
        PH_FINISH: begin
          if (item_i.motor_idle) marker = MRK_SCAN_END;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o.motor_cmd    = cmd;
    res_o.motor_target = target;
    res_o.motor_enable = en_d;
    res_o.marker       = marker;
    res_o.sending      = conn_d;
    res_o.recording    = rec_d;
    res_o.failed       = fail_d;
    res_o.phase_out    = phase_d;
  end

  // state advances once per word handed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      conn_q  <= 1'b0;
      rec_q   <= 1'b0;
      fail_q  <= 1'b0;
      en_q    <= 1'b0;
      timer_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      conn_q  <= conn_d;
      rec_q   <= rec_d;
      fail_q  <= fail_d;
      en_q    <= en_d;
      timer_q <= timer_d;
    end
  end

  // recording only happens on an open connection
  a_rec_conn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_q |-> conn_q) else $error("recording without open connection");

  // a failed scan leaves the driver off
  a_fail_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q |-> !en_q) else $error("driver enabled after failed scan");

  // a failed scan parks the sequencer at idle or a pending start
  a_fail_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q |-> (phase_q == PH_IDLE || phase_q == PH_START))
    else $error("sequencer moved after failed scan");

  // state holds while no word is stepped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(timer_q))
    else $error("state changed without a word");

endmodule

FILE: hw/rtl/pressure_scan_sequencer_unit.sv
`timescale 1ns / 1ps

// Pressure scan sequencer.
// Slave stream: one word per poll, open or close request; tuser carries the
// request kind, tdata the switches, sensor reading and motor status. Master
// stream: one result word per input word (motor command and target, driver
// enable, event marker, flags, phase). Registers are written through the
// cfg port; the user must write them only while no word is in flight, as
// the block itself does not enforce this. A word accepted passes through
// two register stages (input register, result register) with the phase
// logic between them. Throughput is one word per cycle while the master
// side does not stall.
// When the master side stalls, the result register holds its word and the
// input register still takes one more word; further words wait in tready.
// Reset clears all phase state, flags, hold timer and config registers to
// zero and empties both stages; the payload registers are not reset.
module pressure_scan_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // start_switch, home_switch, sensor_value[9:0], motor_position[31:0],
  // motor_max[31:0], dest_reached, motor_idle, ms_elapsed, zero pad
  input  logic [79:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // result words
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // motor_cmd[2:0], motor_target[31:0], motor_enable, marker[2:0], sending,
  // recording, failed, phase_out[3:0], zero pad
  output logic [47:0] m_axis_tdata_o
);
  import psseq_pkg::*;

  cfg_t      cfg_q;
  in_item_t  in_item, stage_item;
  logic      stage_valid;
  logic      advance;
  logic      step;
  out_item_t res, out_q;
  logic      out_valid_q, out_valid_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCAN_LENGTH: cfg_q.scan_length_ms <= cfg_data_i;
        CFG_SCAN_AREA:   cfg_q.scan_area      <= cfg_data_i[15:0];
        CFG_START_VALUE: cfg_q.start_value    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // unpack the input word
  always_comb begin
    in_item.req_type       = s_axis_tuser_i;
    in_item.start_switch   = s_axis_tdata_i[0];
    in_item.home_switch    = s_axis_tdata_i[1];
    in_item.sensor_value   = s_axis_tdata_i[11:2];
    in_item.motor_position = s_axis_tdata_i[43:12];
    in_item.motor_max      = s_axis_tdata_i[75:44];
    in_item.dest_reached   = s_axis_tdata_i[76];
    in_item.motor_idle     = s_axis_tdata_i[77];
    in_item.ms_elapsed     = s_axis_tdata_i[78];
  end

  assign advance = !out_valid_q || m_axis_tready_i;
  assign step    = stage_valid && advance;

  psseq_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  psseq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .step_i (step),
    .item_i (stage_item),
    .res_o  (res)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  // pack the result word
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.phase_out, out_q.failed, out_q.recording,
                            out_q.sending, out_q.marker, out_q.motor_enable,
                            out_q.motor_target, out_q.motor_cmd};

endmodule
